// ----- rtl/sasi_pkg.sv -----
// ----------------------------------------------------------------------------
// sasi_pkg: shared types and constants for the sorted adjacency set insert
// field widths, status codes and the result record passed to the output stage
// ----------------------------------------------------------------------------
package sasi_pkg;

    localparam int DEF_NUM_VERTICES = 256;
    localparam int DEF_MAX_DEGREE   = 16;

    localparam int VTX_W      = 8;   // source / sink vertex fields
    localparam int CFG_W      = 9;   // vertex_count register
    localparam int STATUS_W   = 2;
    localparam int OUT_W      = 5;   // slot and out_degree fields
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    // packed lowest field last so the record lines up with the tdata layout
    typedef struct packed {
        logic [OUT_W-1:0] out_degree;
        logic [OUT_W-1:0] slot;
        status_t          status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ----- rtl/sorted_adjacency_set_insert.sv -----
// ----------------------------------------------------------------------------
// sorted_adjacency_set_insert: per-vertex sorted successor set with degree
// inserts directed edges into sorted, duplicate-free successor lists
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake            contents
//  s_*       in    s_tvalid / s_tready  one edge transaction
//  m_*       out   m_tvalid / m_tready  one result transaction per edge
//  cfg_*     in    cfg_wr_en            vertex_count register write
//
//  after reset the degree table is cleared entry by entry; no edge is taken
//  meanwhile (register writes are)
//  an edge runs a search and a shift-insert, with a duplicate check when the
//  slot is not first; search probes are at most ceil(log2(deg+1)); the pace is
//  set by the single successor memory port: each search probe and each
//  shifted entry is a read followed by a compare or write; out-of-range edges
//  skip the search and go straight to the result
//  one edge is in flight at a time; s_tready is high only when idle
//  a result waits in the output register, so the next edge is accepted while
//  m_tvalid is held against a low m_tready
//
module sorted_adjacency_set_insert #(
    parameter int NUM_VERTICES = sasi_pkg::DEF_NUM_VERTICES,
    parameter int MAX_DEGREE   = sasi_pkg::DEF_MAX_DEGREE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sasi_pkg::S_TDATA_W-1:0] s_tdata,     // source_vertex, sink_vertex
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sasi_pkg::M_TDATA_W-1:0] m_tdata,     // status, slot, out_degree, pad
    input  logic                           cfg_wr_en,
    input  logic [sasi_pkg::CFG_W-1:0]     cfg_wr_data  // vertex_count
);

    import sasi_pkg::*;

    localparam int VW = $clog2(NUM_VERTICES);
    localparam int SW = $clog2(MAX_DEGREE + 1);
    localparam int AW = $clog2(NUM_VERTICES * MAX_DEGREE);

    // vertex count register; the user must write it only while idle, the block does not enforce this
    logic [CFG_W-1:0] vertex_count_reg;

    // result handoff from sequencer to output register
    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             out_valid_reg;
    result_t          out_res_reg;

    // degree table port
    logic             deg_we;
    logic [VW-1:0]    deg_waddr;
    logic [SW-1:0]    deg_wdata;
    logic [VW-1:0]    deg_raddr;
    logic [SW-1:0]    deg_rdata;

    // successor store port, one address shared by read and write
    logic             st_we;
    logic [AW-1:0]    st_addr;
    logic [VTX_W-1:0] st_wdata;
    logic [VTX_W-1:0] st_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    sasi_seq #(
        .NUM_VERTICES (NUM_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .vertex_count (vertex_count_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .deg_we       (deg_we),
        .deg_waddr    (deg_waddr),
        .deg_wdata    (deg_wdata),
        .deg_raddr    (deg_raddr),
        .deg_rdata    (deg_rdata),
        .st_we        (st_we),
        .st_addr      (st_addr),
        .st_wdata     (st_wdata),
        .st_rdata     (st_rdata)
    );

    // out-degree per vertex
    sasi_ram #(
        .DEPTH (NUM_VERTICES),
        .WIDTH (SW)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    // sorted successor lists, MAX_DEGREE entries per vertex
    sasi_ram #(
        .DEPTH (NUM_VERTICES * MAX_DEGREE),
        .WIDTH (VTX_W)
    ) u_succ_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_addr),
        .wdata (st_wdata),
        .raddr (st_addr),
        .rdata (st_rdata)
    );

    // output register: frees the sequencer once the previous result is taken
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_res_reg);

endmodule

// ----- rtl/sasi_ram.sv -----
// ----------------------------------------------------------------------------
// sasi_ram: simple dual-port memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sasi_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sasi_seq.sv -----
// ----------------------------------------------------------------------------
// sasi_seq: sequencer for the sorted successor list insert
// clears the degree table, then per edge runs an upper-bound search and a
// shift-insert through one shared address adder and one compare unit
// ----------------------------------------------------------------------------
module sasi_seq #(
    parameter int NUM_VERTICES = sasi_pkg::DEF_NUM_VERTICES,
    parameter int MAX_DEGREE   = sasi_pkg::DEF_MAX_DEGREE
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              s_tvalid,
    output logic                                              s_tready,
    input  logic [sasi_pkg::S_TDATA_W-1:0]                    s_tdata,
    input  logic [sasi_pkg::CFG_W-1:0]                        vertex_count,
    output logic                                              res_valid,
    input  logic                                              res_ready,
    output sasi_pkg::result_t                                 res,
    output logic                                              deg_we,
    output logic [$clog2(NUM_VERTICES)-1:0]                   deg_waddr,
    output logic [$clog2(MAX_DEGREE+1)-1:0]                   deg_wdata,
    output logic [$clog2(NUM_VERTICES)-1:0]                   deg_raddr,
    input  logic [$clog2(MAX_DEGREE+1)-1:0]                   deg_rdata,
    output logic                                              st_we,
    output logic [$clog2(NUM_VERTICES*MAX_DEGREE)-1:0]        st_addr,
    output logic [sasi_pkg::VTX_W-1:0]                        st_wdata,
    input  logic [sasi_pkg::VTX_W-1:0]                        st_rdata
);

    import sasi_pkg::*;

    localparam int VW = $clog2(NUM_VERTICES);
    localparam int SW = $clog2(MAX_DEGREE + 1);
    localparam int AW = $clog2(NUM_VERTICES * MAX_DEGREE);

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_LOAD     = 10'b0000000100,
        S_SETUP    = 10'b0000001000,
        S_SEARCH   = 10'b0000010000,
        S_PROBE    = 10'b0000100000,
        S_CHECK    = 10'b0001000000,
        S_SHIFT_RD = 10'b0010000000,
        S_SHIFT_WR = 10'b0100000000,
        S_EMIT     = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [VW-1:0]     clr_reg, clr_next;
    logic [VW-1:0]     src_reg, src_next;
    logic [VTX_W-1:0]  snk_reg, snk_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [SW-1:0]     deg_reg, deg_next;
    logic [SW-1:0]     lo_reg, lo_next;
    logic [SW-1:0]     hi_reg, hi_next;
    logic [SW-1:0]     mid_reg, mid_next;
    logic [SW-1:0]     i_reg, i_next;
    result_t           res_reg, res_next;

    logic [VTX_W-1:0]  in_src;
    logic [VTX_W-1:0]  in_snk;
    logic              in_range;
    logic [SW:0]       mid_wide;
    logic [SW-1:0]     mid_sum;
    logic              full_now;
    logic [SW-1:0]     offset;

    assign in_src   = s_tdata[VTX_W-1:0];
    assign in_snk   = s_tdata[2*VTX_W-1:VTX_W];
    assign in_range = (CFG_W'(in_src) < vertex_count) && (CFG_W'(in_snk) < vertex_count)
                   && (32'(in_src) < NUM_VERTICES) && (32'(in_snk) < NUM_VERTICES);

    assign mid_wide = ({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1;
    assign mid_sum  = mid_wide[SW-1:0];
    assign full_now = (deg_reg == SW'(MAX_DEGREE));

    // shared address unit: list base plus the offset picked by the state
    assign st_addr   = base_reg + AW'(offset);
    assign deg_raddr = src_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        src_next   = src_reg;
        snk_next   = snk_reg;
        base_next  = base_reg;
        deg_next   = deg_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        i_next     = i_reg;
        res_next   = res_reg;
        s_tready   = 1'b0;
        res_valid  = 1'b0;
        deg_we     = 1'b0;
        deg_waddr  = src_reg;
        deg_wdata  = SW'(deg_reg + 1'b1);
        st_we      = 1'b0;
        st_wdata   = snk_reg;
        offset     = hi_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                deg_we    = 1'b1;
                deg_waddr = clr_reg;
                deg_wdata = '0;
                if (clr_reg == VW'(NUM_VERTICES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    src_next  = VW'(in_src);
                    snk_next  = in_snk;
                    base_next = AW'(VW'(in_src)) * AW'(MAX_DEGREE);
                    if (in_range)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        res_next   = '{out_degree: '0, slot: '0, status: ST_RANGE};
                        state_next = S_EMIT;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                deg_next   = deg_rdata;
                lo_next    = '0;
                hi_next    = deg_rdata;
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    offset     = mid_sum;
                    mid_next   = mid_sum;
                    state_next = S_PROBE;
                end
                else if (hi_reg != '0)
                begin
                    offset     = SW'(hi_reg - 1'b1);
                    state_next = S_CHECK;
                end
                else if (full_now)
                begin
                    res_next   = '{out_degree: OUT_W'(deg_reg), slot: OUT_W'(hi_reg),
                                   status: ST_FULL};
                    state_next = S_EMIT;
                end
                else
                begin
                    i_next     = deg_reg;
                    state_next = S_SHIFT_RD;
                end
            end
            S_PROBE:
            begin
                if (st_rdata > snk_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = SW'(mid_reg + 1'b1);
                end
                state_next = S_SEARCH;
            end
            S_CHECK:
            begin
                if (st_rdata == snk_reg)
                begin
                    res_next   = '{out_degree: OUT_W'(deg_reg),
                                   slot: OUT_W'(SW'(hi_reg - 1'b1)), status: ST_PRESENT};
                    state_next = S_EMIT;
                end
                else if (full_now)
                begin
                    res_next   = '{out_degree: OUT_W'(deg_reg), slot: OUT_W'(hi_reg),
                                   status: ST_FULL};
                    state_next = S_EMIT;
                end
                else
                begin
                    i_next     = deg_reg;
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (i_reg > hi_reg)
                begin
                    offset     = SW'(i_reg - 1'b1);
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    // gap is open: drop the sink in and bump the degree
                    offset     = hi_reg;
                    st_we      = 1'b1;
                    st_wdata   = snk_reg;
                    deg_we     = 1'b1;
                    res_next   = '{out_degree: OUT_W'(SW'(deg_reg + 1'b1)),
                                   slot: OUT_W'(hi_reg), status: ST_INSERTED};
                    state_next = S_EMIT;
                end
            end
            S_SHIFT_WR:
            begin
                offset     = i_reg;
                st_we      = 1'b1;
                st_wdata   = st_rdata;
                i_next     = SW'(i_reg - 1'b1);
                state_next = S_SHIFT_RD;
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        snk_reg  <= snk_next;
        base_reg <= base_next;
        deg_reg  <= deg_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        i_reg    <= i_next;
        res_reg  <= res_next;
    end

    // search window stays inside the current list
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_reg <= hi_reg) && (hi_reg <= deg_reg))
        else $error("search window outside list");

    // a full list is never written
    assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> !full_now)
        else $error("write into full list");

    // shift moves entries only above the insert slot and up to the degree
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_WR) |-> (i_reg > hi_reg) && (i_reg <= deg_reg))
        else $error("shift index out of bounds");

    // duplicate check only runs on a non-empty prefix
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (hi_reg != '0))
        else $error("duplicate check with empty prefix");

endmodule
